// ===== rtl/pmfb_pkg.sv =====
// ============================================================================
// pmfb_pkg
// Shared types, geometry constants and address helpers for the paged
// monochrome framebuffer blit core.
// ============================================================================
package pmfb_pkg;

    // display geometry
    localparam int DISPLAY_WIDTH  = 128;
    localparam int DISPLAY_HEIGHT = 64;
    localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + 7) / 8;
    localparam int STORE_BYTES    = DISPLAY_WIDTH * PAGE_COUNT;
    localparam int ADDR_W         = $clog2(STORE_BYTES);

    // field widths
    localparam int COORD_W = 8;
    localparam int LEFT_W  = 13;
    localparam int QUEUE_DEPTH = 2;

    // item kinds carried on tuser
    typedef enum logic [1:0] {
        OP_SET   = 2'd0,
        OP_GET   = 2'd1,
        OP_START = 2'd2,
        OP_DATA  = 2'd3
    } t_op;

    // decoded word passed from front to back
    typedef struct packed {
        t_op                 op;
        logic                on_screen;
        logic [ADDR_W-1:0]   addr;
        logic [2:0]          bit_sel;
        logic                pixel_value;
        logic [COORD_W-1:0]  x_coord;
        logic [COORD_W-1:0]  y_coord;
        logic [COORD_W-1:0]  blit_width;
        logic [COORD_W-1:0]  blit_height;
        logic [7:0]          bitmap_byte;
        logic [LEFT_W-1:0]   blit_len;
    } t_cmd;

    // back status seen by the front
    typedef struct packed {
        logic clearing;
    } t_back_stat;

    // pixel lies inside the display
    function automatic logic on_screen(input logic [COORD_W-1:0] x,
                                       input logic [COORD_W-1:0] y);
        return ({1'b0, x} < (COORD_W+1)'(DISPLAY_WIDTH)) &&
               ({1'b0, y} < (COORD_W+1)'(DISPLAY_HEIGHT));
    endfunction

    // byte address of a pixel: page row times width plus column
    function automatic logic [ADDR_W-1:0] pix_addr(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y);
        logic [ADDR_W+COORD_W-1:0] t;
        t = (ADDR_W+COORD_W)'(DISPLAY_WIDTH) * (ADDR_W+COORD_W)'(y[COORD_W-1:3])
            + (ADDR_W+COORD_W)'(x);
        return t[ADDR_W-1:0];
    endfunction

endpackage

// ===== rtl/pmfb_front.sv =====
// ============================================================================
// pmfb_front
// Accepts input words, classifies them and precomputes store address, bit
// position, clipping and blit length before they enter the queue.
// ============================================================================
module pmfb_front
    import pmfb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_op                i_op,
    input  logic [COORD_W-1:0] i_x_coord,
    input  logic [COORD_W-1:0] i_y_coord,
    input  logic               i_pixel_value,
    input  logic [COORD_W-1:0] i_blit_width,
    input  logic [COORD_W-1:0] i_blit_height,
    input  logic [7:0]         i_bitmap_byte,
    input  logic               i_queue_full,
    input  t_back_stat         i_back_stat,
    output logic               o_push,
    output t_cmd               o_cmd
);

    logic [2*COORD_W-1:0] area;
    logic                 r_ready;

    // hold off input until the back is out of its clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= !i_back_stat.clearing;
        end
    end

    assign o_ready = r_ready && !i_back_stat.clearing && !i_queue_full;
    assign o_push  = i_valid && o_ready;

    // classify and precompute
    assign area = (2*COORD_W)'(i_blit_width) * (2*COORD_W)'(i_blit_height);

    always_comb begin
        o_cmd.op          = i_op;
        o_cmd.on_screen   = on_screen(i_x_coord, i_y_coord);
        o_cmd.addr        = pix_addr(i_x_coord, i_y_coord);
        o_cmd.bit_sel     = i_y_coord[2:0];
        o_cmd.pixel_value = i_pixel_value;
        o_cmd.x_coord     = i_x_coord;
        o_cmd.y_coord     = i_y_coord;
        o_cmd.blit_width  = i_blit_width;
        o_cmd.blit_height = i_blit_height;
        o_cmd.bitmap_byte = i_bitmap_byte;
        o_cmd.blit_len    = area[2*COORD_W-1:3];
    end

endmodule

// ===== rtl/pmfb_queue.sv =====
// ============================================================================
// pmfb_queue
// Short FIFO of decoded words between front and back.
// ============================================================================
module pmfb_queue
    import pmfb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_cmd             r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             do_pop;

    assign o_full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_entry[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // store payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/pmfb_back.sv =====
// ============================================================================
// pmfb_back
// Executes decoded words against the paged frame store: pixel read and
// read-modify-write, blit cursor stepping, and the registered result word.
// ============================================================================
module pmfb_back
    import pmfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output t_back_stat o_stat,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_pixel_read,
    output logic       o_blit_busy
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SET_WR,
        S_BLIT_RD,
        S_BLIT_WR,
        S_RESULT
    } t_state;

    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [ADDR_W-1:0]  r_clr_addr, n_clr_addr;
    logic [COORD_W-1:0] r_col, n_col;
    logic [COORD_W-1:0] r_row, n_row;
    logic [COORD_W-1:0] r_org_col, n_org_col;
    logic [COORD_W-1:0] r_org_row, n_org_row;
    logic [COORD_W-1:0] r_width, n_width;
    logic [COORD_W-1:0] r_height, n_height;
    logic [LEFT_W-1:0]  r_left, n_left;
    logic [2:0]         r_step, n_step;
    logic               r_out_valid, n_out_valid;
    logic               r_pixel_read, n_pixel_read;
    logic               r_blit_busy, n_blit_busy;

    // frame store
    logic [7:0]         r_store [STORE_BYTES];
    logic [7:0]         r_rd_data;
    logic               mem_we;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_addr;
    logic [7:0]         mem_wdata;

    // blit cursor stepping
    logic               cur_on;
    logic [ADDR_W-1:0]  cur_addr;
    logic               cur_pix;
    logic [7:0]         cur_mask;
    logic [COORD_W-1:0] col_inc;
    logic               col_wrap;
    logic [COORD_W-1:0] step_col;
    logic [COORD_W-1:0] step_row;
    logic [COORD_W-1:0] col_off;
    logic [COORD_W-1:0] row_off;
    logic               height_hit;
    logic [7:0]         set_mask;
    logic               out_free;

    assign cur_on   = on_screen(r_col, r_row);
    assign cur_addr = pix_addr(r_col, r_row);
    assign cur_pix  = r_cmd.bitmap_byte[~r_step];
    assign cur_mask = 8'h01 << r_row[2:0];
    assign col_inc  = r_col + 1'b1;
    assign col_off  = col_inc - r_org_col;
    assign col_wrap = (col_off == r_width);
    assign step_col = col_wrap ? r_org_col : col_inc;
    assign step_row = col_wrap ? r_row + 1'b1 : r_row;
    assign row_off  = step_row - r_org_row;
    assign height_hit = (row_off == r_height);
    assign set_mask = 8'h01 << r_cmd.bit_sel;
    assign out_free = !r_out_valid || i_out_ready;

    assign o_stat.clearing = (r_state == S_CLEAR);
    assign o_pop           = (r_state == S_IDLE) && i_cmd_valid;
    assign o_out_valid     = r_out_valid;
    assign o_pixel_read    = r_pixel_read;
    assign o_blit_busy     = r_blit_busy;

    // sequence the work of one word
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_clr_addr   = r_clr_addr;
        n_col        = r_col;
        n_row        = r_row;
        n_org_col    = r_org_col;
        n_org_row    = r_org_row;
        n_width      = r_width;
        n_height     = r_height;
        n_left       = r_left;
        n_step       = r_step;
        n_out_valid  = r_out_valid;
        n_pixel_read = r_pixel_read;
        n_blit_busy  = r_blit_busy;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_addr     = cur_addr;
        mem_wdata    = '0;

        // drop the result once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                mem_we     = 1'b1;
                mem_addr   = r_clr_addr;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(STORE_BYTES-1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd    = i_cmd;
                    mem_addr = i_cmd.addr;
                    n_state  = S_RESULT;
                    case (i_cmd.op)
                        OP_SET: begin
                            if (i_cmd.on_screen) begin
                                mem_re  = 1'b1;
                                n_state = S_SET_WR;
                            end
                        end
                        OP_GET: begin
                            mem_re = i_cmd.on_screen;
                        end
                        OP_START: begin
                            n_org_col = i_cmd.x_coord;
                            n_org_row = i_cmd.y_coord;
                            n_col     = i_cmd.x_coord;
                            n_row     = i_cmd.y_coord;
                            n_width   = i_cmd.blit_width;
                            n_height  = i_cmd.blit_height;
                            n_left    = i_cmd.blit_len;
                        end
                        default: begin
                            if (r_left != '0) begin
                                n_left  = r_left - 1'b1;
                                n_step  = '0;
                                n_state = S_BLIT_RD;
                            end
                        end
                    endcase
                end
            end
            S_SET_WR: begin
                mem_we    = 1'b1;
                mem_addr  = r_cmd.addr;
                mem_wdata = r_cmd.pixel_value ? (r_rd_data | set_mask)
                                              : (r_rd_data & ~set_mask);
                n_state   = S_RESULT;
            end
            S_BLIT_RD, S_BLIT_WR: begin
                if ((r_state == S_BLIT_RD) && cur_on) begin
                    // fetch the byte under the cursor
                    mem_re  = 1'b1;
                    n_state = S_BLIT_WR;
                end else begin
                    // merge the pixel if on screen, then advance the cursor
                    mem_we    = (r_state == S_BLIT_WR);
                    mem_wdata = cur_pix ? (r_rd_data | cur_mask)
                                        : (r_rd_data & ~cur_mask);
                    n_col     = step_col;
                    n_row     = step_row;
                    n_step    = r_step + 1'b1;
                    if (height_hit) begin
                        n_left  = '0;
                        n_state = S_RESULT;
                    end else if (r_step == 3'd7) begin
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_BLIT_RD;
                    end
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_pixel_read = (r_cmd.op == OP_GET) && r_cmd.on_screen &&
                                   r_rd_data[r_cmd.bit_sel];
                    n_blit_busy  = (r_left != '0);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_org_col   <= '0;
            r_org_row   <= '0;
            r_width     <= '0;
            r_height    <= '0;
            r_left      <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_col       <= n_col;
            r_row       <= n_row;
            r_org_col   <= n_org_col;
            r_org_row   <= n_org_row;
            r_width     <= n_width;
            r_height    <= n_height;
            r_left      <= n_left;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
        r_cmd        <= n_cmd;
        r_pixel_read <= n_pixel_read;
        r_blit_busy  <= n_blit_busy;
    end

    // single-port frame store with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_store[mem_addr];
        end
    end

    // clearing pass writes zeros only
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (mem_we && (mem_wdata == 8'h00)))
        else $error("clearing pass wrote nonzero data");

    // a blit write always follows the read of the same cursor byte
    a_blit_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BLIT_WR) |-> ($past(r_state) == S_BLIT_RD) && $stable(r_col)
                                   && $stable(r_row))
        else $error("blit write without matching read");

    // blit stepping only runs for a data word
    a_blit_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_BLIT_RD) || (r_state == S_BLIT_WR)) |-> (r_cmd.op == OP_DATA))
        else $error("blit stepping for a non-data word");

    // a word taken from the queue starts execution on the next cycle
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state != S_IDLE) && (r_state != S_CLEAR))
        else $error("popped word did not start execution");

endmodule

// ===== rtl/paged_mono_framebuffer_blit_core.sv =====
// ============================================================================
// paged_mono_framebuffer_blit_core
// Paged monochrome framebuffer with pixel set/get and streaming bitmap blit.
// ============================================================================
// After reset the core runs a clearing pass over the frame store, one byte a
// cycle over all STORE_BYTES bytes (1024 at 128x64), and takes no input word
// until it ends. Every accepted word gives one result word. The back end works
// one word at a time on a single-port store with a registered read: a set
// reads the byte and then writes it back merged, a get reads the byte, and a
// blit data word reads and writes back the byte under each on-screen pixel
// and steps over clipped pixels, up to eight pixels per word. A two-word queue
// lets the input side keep accepting while the back end or a stalled result
// is busy.
// ============================================================================
module paged_mono_framebuffer_blit_core
    import pmfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] x_coord, [15:8] y_coord, [16] pixel_value, [24:17] blit_width,
    // [32:25] blit_height, [40:33] bitmap_byte, [47:41] zero
    input  logic [47:0] s_axis_tdata,
    // [1:0] op
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] pixel_read, [1] blit_busy, [7:2] zero
    output logic [7:0]  m_axis_tdata
);

    logic       push;
    logic       queue_full;
    logic       queue_valid;
    logic       pop;
    t_cmd       front_cmd;
    t_cmd       queue_cmd;
    t_back_stat back_stat;
    logic       pixel_read;
    logic       blit_busy;

    // classify incoming words
    pmfb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_op          (t_op'(s_axis_tuser)),
        .i_x_coord     (s_axis_tdata[7:0]),
        .i_y_coord     (s_axis_tdata[15:8]),
        .i_pixel_value (s_axis_tdata[16]),
        .i_blit_width  (s_axis_tdata[24:17]),
        .i_blit_height (s_axis_tdata[32:25]),
        .i_bitmap_byte (s_axis_tdata[40:33]),
        .i_queue_full  (queue_full),
        .i_back_stat   (back_stat),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    // decouple front and back
    pmfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    // execute against the frame store
    pmfb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (queue_valid),
        .i_cmd        (queue_cmd),
        .o_pop        (pop),
        .o_stat       (back_stat),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_pixel_read (pixel_read),
        .o_blit_busy  (blit_busy)
    );

    assign m_axis_tdata = {6'b0, blit_busy, pixel_read};

endmodule
